// ----- sv/fmss_pkg.sv -----
// Shared types, constants and the seven-segment decode for the frequency meter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fmss_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = 16;
    localparam int FRAME_W    = 8;
    localparam int POS_W      = 2;
    localparam int SEG_W      = 8;

    localparam logic [CNT_W-1:0]   GATE_TICKS_RST = 16'd1000;
    localparam logic [FRAME_W-1:0] FRAMES_RST     = 8'd20;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
    localparam logic [POS_W-1:0] POS_UNITS     = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_GATE_TICKS = 1'b0;
    localparam logic REG_FRAMES     = 1'b1;

    typedef logic [DIGIT_W-1:0] t_digit;

    // Per-item control that every decade cell sees.
    typedef struct packed {
        logic hold;    // count would pass 9999, keep the digits
        logic close;   // gate window closes with this item
        logic reload;  // display reloads from the latched value
    } t_cell_ctl;

    // Active-low common-anode patterns; bit 7 is the decimal point, kept off.
    function automatic logic [SEG_W-1:0] seg_decode(input t_digit d);
        logic [SEG_W-1:0] seg;
        case (d)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fmss_decade.sv -----
// One decimal digit of the frequency meter: running count, latched value and shown value.
// Depends on fmss_pkg; instantiated in a carry chain by the top level.
`default_nettype none

module fmss_decade
    import fmss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_carry,
    input  wire t_cell_ctl i_ctl,
    output logic           o_carry,
    output t_digit         o_shown
);

    t_digit r_cnt, r_lat, r_shown;
    t_digit n_cnt_inc, n_cnt, n_lat, n_shown;

    // A digit at nine that is incremented hands a carry to the next decade.
    assign o_carry = i_carry && (r_cnt == DIGIT_MAX);

    always_comb begin
        n_cnt_inc = r_cnt;
        if (i_carry && !i_ctl.hold) begin
            n_cnt_inc = (r_cnt == DIGIT_MAX) ? '0 : r_cnt + t_digit'(1);
        end
        n_cnt   = i_ctl.close  ? '0        : n_cnt_inc;
        n_lat   = i_ctl.close  ? n_cnt_inc : r_lat;
        n_shown = i_ctl.reload ? n_lat     : r_shown;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_lat   <= '0;
            r_shown <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_lat   <= n_lat;
            r_shown <= n_shown;
        end
    end

    assign o_shown = r_shown;

endmodule

`default_nettype wire

// ----- sv/fmss_gate.sv -----
// Binary edge counter and gate window counter; latches the measured frequency.
// Depends on fmss_pkg.
`default_nettype none

module fmss_gate
    import fmss_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_edge,
    input  wire logic             i_tick,
    input  wire logic [CNT_W-1:0] i_gate_ticks,
    output logic                  o_close,
    output logic [CNT_W-1:0]      o_freq
);

    logic [CNT_W-1:0] r_edge_cnt, r_gate_cnt, r_freq;
    logic [CNT_W-1:0] n_edge_inc, n_gate_inc;

    // Both counters stop at all ones.
    assign n_edge_inc = (i_edge && (r_edge_cnt != '1)) ? r_edge_cnt + 1'b1 : r_edge_cnt;
    assign n_gate_inc = (r_gate_cnt != '1) ? r_gate_cnt + 1'b1 : r_gate_cnt;
    assign o_close    = i_tick && (n_gate_inc >= i_gate_ticks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt <= '0;
            r_gate_cnt <= '0;
            r_freq     <= '0;
        end else if (o_close) begin
            r_freq     <= n_edge_inc;
            r_edge_cnt <= '0;
            r_gate_cnt <= '0;
        end else begin
            r_edge_cnt <= n_edge_inc;
            if (i_tick) begin
                r_gate_cnt <= n_gate_inc;
            end
        end
    end

    assign o_freq = r_freq;

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_close |=> (r_edge_cnt == '0) && (r_gate_cnt == '0))
        else $error("counters not cleared after window close");

endmodule

`default_nettype wire

// ----- sv/fmss_scan.sv -----
// Display scan: digit position and full-scan frame counter that paces reloads.
// Depends on fmss_pkg.
`default_nettype none

module fmss_scan
    import fmss_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tick,
    input  wire logic [FRAME_W-1:0] i_frames,
    output logic [POS_W-1:0]        o_pos,
    output logic                    o_reload
);

    logic [POS_W-1:0]   r_pos;
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] n_frame_inc;
    logic               w_wrap;

    assign w_wrap      = i_tick && (r_pos == POS_UNITS);
    assign n_frame_inc = (r_frame != '1) ? r_frame + 1'b1 : r_frame;
    assign o_reload    = w_wrap && (n_frame_inc >= i_frames);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_THOUSANDS;
            r_frame <= '0;
        end else if (i_tick) begin
            if (w_wrap) begin
                r_pos   <= POS_THOUSANDS;
                r_frame <= o_reload ? '0 : n_frame_inc;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    assign o_pos = r_pos;

endmodule

`default_nettype wire

// ----- sv/frequency_meter_seven_segment.sv -----
// Gated frequency counter with a four-digit multiplexed seven-segment display.
// Each input transfer carries an edge flag, a gate tick and a scan tick; the block
// takes one transfer per clock while o_ready is high and returns one result transfer
// for each from an output register (o_ready stays high while the result is taken or
// the register is empty). Edges are counted in binary for o_measured_frequency and,
// in parallel, in a chain of four decimal cells (units to thousands) whose carry
// ripples combinationally through the row; that chain also holds the latched and the
// shown value digit by digit, so no binary-to-decimal conversion is needed and a
// count past 9999 simply stops the chain and raises the over-range flag. A window
// closes when the gate counter reaches gate_ticks (register 0, address 0); the shown
// value reloads every frames_per_refresh full scans (register 1, address 4).
// Depends on fmss_pkg, fmss_decade, fmss_gate and fmss_scan.
`default_nettype none

module frequency_meter_seven_segment
    import fmss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,

    // Input channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_pulse_edge,
    input  wire logic              i_gate_tick,
    input  wire logic              i_scan_tick,

    // Output channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [SEG_W-1:0]       o_segments,
    output logic [NUM_DIGITS-1:0]  o_digit_enables,
    output logic [CNT_W-1:0]       o_measured_frequency,
    output logic                   o_measurement_done,
    output logic                   o_over_range
);

    // Configuration registers. pready is tied high, so a write lands at the
    // access cycle of the transfer.
    logic [CNT_W-1:0]   r_gate_ticks;
    logic [FRAME_W-1:0] r_frames;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_ticks <= GATE_TICKS_RST;
            r_frames     <= FRAMES_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_GATE_TICKS: r_gate_ticks <= pwdata[CNT_W-1:0];
                REG_FRAMES:     r_frames     <= pwdata[FRAME_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GATE_TICKS: prdata = {{(32-CNT_W){1'b0}}, r_gate_ticks};
            REG_FRAMES:     prdata = {{(32-FRAME_W){1'b0}}, r_frames};
            default:        prdata = '0;
        endcase
    end

    // Handshake. All state updates happen only on an accepted input transfer, and
    // the result fields are read straight from that state, so they hold while the
    // output side stalls because no new transfer is taken then.
    logic r_valid;
    logic w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !i_ready);
        end
    end

    // Gate window and binary measurement.
    logic w_close;

    fmss_gate u_gate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_edge       (w_accept && i_pulse_edge),
        .i_tick       (w_accept && i_gate_tick),
        .i_gate_ticks (r_gate_ticks),
        .o_close      (w_close),
        .o_freq       (o_measured_frequency)
    );

    // Digit scan and reload pacing.
    logic [POS_W-1:0] w_pos;
    logic             w_reload;

    fmss_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_accept && i_scan_tick),
        .i_frames (r_frames),
        .o_pos    (w_pos),
        .o_reload (w_reload)
    );

    // Decimal chain. Cell 0 is the units digit. Once the count has passed 9999 the
    // over flag is set and no further carry enters the chain, so the digits rest at
    // 9999, which is exactly the clamped display value.
    logic                r_cnt_ovf, r_lat_ovf, r_shown_over;
    logic                n_cnt_ovf, n_lat_ovf;
    logic [NUM_DIGITS:0] w_carry;
    t_digit              w_shown [NUM_DIGITS];
    t_cell_ctl           w_ctl;

    assign w_carry[0]   = w_accept && i_pulse_edge && !r_cnt_ovf;
    assign w_ctl.hold   = w_carry[NUM_DIGITS];
    assign w_ctl.close  = w_close;
    assign w_ctl.reload = w_reload;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_decade
        fmss_decade u_decade (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_carry (w_carry[g]),
            .i_ctl   (w_ctl),
            .o_carry (w_carry[g+1]),
            .o_shown (w_shown[g])
        );
    end

    // The over-range flags follow the digits through count, latch and display.
    assign n_cnt_ovf = r_cnt_ovf || w_carry[NUM_DIGITS];
    assign n_lat_ovf = w_close ? n_cnt_ovf : r_lat_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_ovf          <= 1'b0;
            r_lat_ovf          <= 1'b0;
            r_shown_over       <= 1'b0;
            o_measurement_done <= 1'b0;
        end else if (w_accept) begin
            r_cnt_ovf          <= w_close ? 1'b0 : n_cnt_ovf;
            r_lat_ovf          <= n_lat_ovf;
            o_measurement_done <= w_close;
            if (w_reload) begin
                r_shown_over <= n_lat_ovf;
            end
        end
    end

    assign o_over_range = r_shown_over;

    // Position 0 is the thousands digit, which is the top cell of the chain.
    assign o_segments      = seg_decode(w_shown[POS_UNITS - w_pos]);
    assign o_digit_enables = ~(NUM_DIGITS'(1) << w_pos);

    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(~o_digit_enables))
        else $error("not exactly one digit enabled");

    a_clamp_shows_nines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shown_over |-> (w_shown[0] == DIGIT_MAX) && (w_shown[1] == DIGIT_MAX) &&
                         (w_shown[2] == DIGIT_MAX) && (w_shown[3] == DIGIT_MAX))
        else $error("over-range display is not 9999");

    a_over_only_on_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_reload |=> $stable(r_shown_over))
        else $error("over-range flag changed without a reload");

endmodule

`default_nettype wire
